[src/prm_pkg.sv]
// Shared types and constants for the power rail monitor trip unit.
package prm_pkg;

    localparam int SAMPLE_BITS = 3;

    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;

    localparam logic [15:0] FAST_EMPTY_DIV = 16'd56;
    localparam logic [15:0] SLOW_EMPTY_DIV = 16'd100;

    localparam logic [9:0]        PEAK_LIM_RST  = 10'd1023;
    localparam logic [9:0]        LOWV_LIM_RST  = 10'd0;
    localparam logic [9:0]        HIGHV_LIM_RST = 10'd1023;
    localparam logic [9:0]        AVEC_LIM_RST  = 10'd1023;
    localparam logic signed [7:0] TEMP_LIM_RST  = 8'sd127;
    localparam logic [7:0]        GRACE_RST     = 8'd100;

    typedef enum logic [IN_TUSER_W-1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_FAST   = 2'd1,
        KIND_SLOW   = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PEAK_LIM  = 3'd0,
        CFG_LOWV_LIM  = 3'd1,
        CFG_HIGHV_LIM = 3'd2,
        CFG_AVEC_LIM  = 3'd3,
        CFG_TEMP_LIM  = 3'd4,
        CFG_GRACE     = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIV_VOLT = 2'd0,
        DIV_AMP  = 2'd1,
        DIV_SLOW = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     take;
        logic     div_start;
        t_div_sel div_sel;
        logic     fin_volt;
        logic     fin_amp;
        logic     fin_slow;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

    typedef struct packed {
        logic signed [15:0] slow_current;
        logic signed [15:0] avg_current;
        logic [15:0]        avg_voltage;
        logic signed [10:0] sample_current;
        logic               high_temp_trip;
        logic               ave_current_trip;
        logic               high_voltage_trip;
        logic               low_voltage_trip;
        logic               peak_current_trip;
    } t_res;

endpackage

[src/prm_div.sv]
// Serial restoring divider, 32 or 16 bit dividend by 16 bit divisor, two bits per cycle.
module prm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_long,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic [31:0] o_quo,
    output logic        o_done
);
    import prm_pkg::*;

    localparam logic [4:0] STEPS_LONG  = 5'd16;
    localparam logic [4:0] STEPS_SHORT = 5'd8;

    logic [15:0] r_rem;
    logic [31:0] r_quo;
    logic [15:0] r_dvs;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [16:0] w_t0;
    logic [16:0] w_t1;
    logic        w_b0;
    logic        w_b1;
    logic [15:0] w_rem0;
    logic [31:0] w_quo0;
    logic [15:0] n_rem;
    logic [31:0] n_quo;

    always_comb begin
        w_t0   = {r_rem, r_quo[31]};
        w_b0   = w_t0 >= {1'b0, r_dvs};
        w_rem0 = w_b0 ? 16'(w_t0 - {1'b0, r_dvs}) : w_t0[15:0];
        w_quo0 = {r_quo[30:0], w_b0};
        w_t1   = {w_rem0, w_quo0[31]};
        w_b1   = w_t1 >= {1'b0, r_dvs};
        n_rem  = w_b1 ? 16'(w_t1 - {1'b0, r_dvs}) : w_t1[15:0];
        n_quo  = {w_quo0[30:0], w_b1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_long ? STEPS_LONG : STEPS_SHORT;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_long ? i_dividend : {i_dividend[15:0], 16'd0};
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

[src/prm_dpath.sv]
// Datapath: limit registers, running sums, divider operands, result and output registers.
module prm_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [prm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [prm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [prm_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input  logic [prm_pkg::IN_TUSER_W-1:0] i_s_tuser,
    input  logic                          i_s_tlast,
    input  prm_pkg::t_cmd                 i_cmd,
    output prm_pkg::t_stat                o_stat,
    output logic [prm_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import prm_pkg::*;

    logic [9:0]        r_peak_lim;
    logic [9:0]        r_lowv_lim;
    logic [9:0]        r_highv_lim;
    logic [9:0]        r_avec_lim;
    logic signed [7:0] r_temp_lim;
    logic [7:0]        r_grace_lim;

    logic [15:0] r_volt_sum;
    logic [15:0] r_amp_sum;
    logic [15:0] r_blocks;
    logic [31:0] r_long_sum;
    logic [15:0] r_ticks;
    logic [7:0]  r_grace;
    logic [15:0] r_volt_rd;
    logic [15:0] r_amp_rd;

    logic signed [7:0] r_temp;
    t_res              r_res;
    t_res              n_res;
    t_res              r_out;

    logic [9:0]         w_ref;
    logic [9:0]         w_volt;
    logic [9:0]         w_amp;
    logic signed [7:0]  w_temp;
    logic signed [10:0] w_cur;
    logic signed [11:0] w_cur12;
    logic signed [11:0] w_plim;
    logic               w_peak;
    logic signed [15:0] w_cur16;
    logic [15:0]        w_amp_inc;
    logic [15:0]        w_volt_inc;

    logic [15:0] w_fast_n;
    logic [15:0] w_slow_n;
    logic [15:0] w_amp_mag;
    logic [31:0] w_long_mag;
    logic        w_div_long;
    logic [31:0] w_div_dvd;
    logic [15:0] w_div_dvs;
    logic [31:0] w_quo;
    logic        w_div_done;

    logic [15:0]        w_amp_avg;
    logic               w_grace_on;
    logic               w_lowv;
    logic               w_highv;
    logic [15:0]        w_slow;
    logic signed [16:0] w_slow17;
    logic signed [16:0] w_alim17;
    logic               w_avec;
    logic               w_hot;

    assign w_ref  = i_s_tdata[9:0];
    assign w_volt = i_s_tdata[19:10];
    assign w_amp  = i_s_tdata[29:20];
    assign w_temp = i_s_tdata[37:30];

    assign w_cur      = $signed({1'b0, w_amp}) - $signed({1'b0, w_ref});
    assign w_cur12    = {w_cur[10], w_cur};
    assign w_plim     = $signed({2'b00, r_peak_lim});
    assign w_peak     = (w_cur12 > w_plim) || (w_cur12 < -w_plim);
    assign w_cur16    = {{5{w_cur[10]}}, w_cur};
    assign w_amp_inc  = w_cur16 >>> SAMPLE_BITS;
    assign w_volt_inc = {6'd0, w_volt} >> SAMPLE_BITS;

    assign w_fast_n   = (r_blocks == 16'd0) ? FAST_EMPTY_DIV : r_blocks;
    assign w_slow_n   = (r_ticks == 16'd0) ? SLOW_EMPTY_DIV : r_ticks;
    assign w_amp_mag  = r_amp_sum[15] ? 16'(-r_amp_sum) : r_amp_sum;
    assign w_long_mag = r_long_sum[31] ? 32'(-r_long_sum) : r_long_sum;

    always_comb begin
        case (i_cmd.div_sel)
            DIV_VOLT: begin
                w_div_long = 1'b0;
                w_div_dvd  = {16'd0, r_volt_sum};
                w_div_dvs  = w_fast_n;
            end
            DIV_AMP: begin
                w_div_long = 1'b0;
                w_div_dvd  = {16'd0, w_amp_mag};
                w_div_dvs  = w_fast_n;
            end
            DIV_SLOW: begin
                w_div_long = 1'b1;
                w_div_dvd  = w_long_mag;
                w_div_dvs  = w_slow_n;
            end
            default: begin
                w_div_long = 1'b0;
                w_div_dvd  = '0;
                w_div_dvs  = FAST_EMPTY_DIV;
            end
        endcase
    end

    prm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_long     (w_div_long),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_quo      (w_quo),
        .o_done     (w_div_done)
    );

    assign w_amp_avg  = r_amp_sum[15] ? 16'(-w_quo[15:0]) : w_quo[15:0];
    assign w_grace_on = r_grace >= r_grace_lim;
    assign w_lowv     = w_grace_on && (r_volt_rd < {6'd0, r_lowv_lim});
    assign w_highv    = r_volt_rd > {6'd0, r_highv_lim};

    always_comb begin
        if (!r_long_sum[31]) begin
            w_slow = (w_quo > 32'd32767) ? 16'h7FFF : w_quo[15:0];
        end else begin
            w_slow = (w_quo > 32'd32768) ? 16'h8000 : 16'(-w_quo[15:0]);
        end
    end

    assign w_slow17 = {w_slow[15], w_slow};
    assign w_alim17 = $signed({7'd0, r_avec_lim});
    assign w_avec   = (w_slow17 > w_alim17) || (w_slow17 < -w_alim17);
    assign w_hot    = r_temp > r_temp_lim;

    // limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_lim  <= PEAK_LIM_RST;
            r_lowv_lim  <= LOWV_LIM_RST;
            r_highv_lim <= HIGHV_LIM_RST;
            r_avec_lim  <= AVEC_LIM_RST;
            r_temp_lim  <= TEMP_LIM_RST;
            r_grace_lim <= GRACE_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PEAK_LIM:  r_peak_lim  <= i_cfg_data;
                CFG_LOWV_LIM:  r_lowv_lim  <= i_cfg_data;
                CFG_HIGHV_LIM: r_highv_lim <= i_cfg_data;
                CFG_AVEC_LIM:  r_avec_lim  <= i_cfg_data;
                CFG_TEMP_LIM:  r_temp_lim  <= i_cfg_data[7:0];
                CFG_GRACE:     r_grace_lim <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // monitor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt_sum <= '0;
            r_amp_sum  <= '0;
            r_blocks   <= '0;
            r_long_sum <= '0;
            r_ticks    <= '0;
            r_grace    <= '0;
            r_volt_rd  <= '0;
            r_amp_rd   <= '0;
        end else begin
            if (i_cmd.take && (t_kind'(i_s_tuser) == KIND_SAMPLE)) begin
                r_volt_sum <= r_volt_sum + w_volt_inc;
                r_amp_sum  <= r_amp_sum + w_amp_inc;
                r_blocks   <= r_blocks + {15'd0, i_s_tlast};
            end
            if (i_cmd.fin_volt) begin
                r_volt_rd <= w_quo[15:0];
            end
            if (i_cmd.fin_amp) begin
                r_amp_rd   <= w_amp_avg;
                r_volt_sum <= '0;
                r_amp_sum  <= '0;
                r_blocks   <= '0;
                r_long_sum <= r_long_sum + {{16{w_amp_avg[15]}}, w_amp_avg};
                r_ticks    <= r_ticks + 16'd1;
                if (!w_grace_on) begin
                    r_grace <= r_grace + 8'd1;
                end
            end
            if (i_cmd.fin_slow) begin
                r_ticks    <= '0;
                r_long_sum <= '0;
            end
        end
    end

    // item result
    always_comb begin
        n_res = r_res;
        if (i_cmd.take) begin
            n_res             = '0;
            n_res.avg_voltage = r_volt_rd;
            n_res.avg_current = r_amp_rd;
            if (t_kind'(i_s_tuser) == KIND_SAMPLE) begin
                n_res.sample_current    = w_cur;
                n_res.peak_current_trip = w_peak;
            end
        end
        if (i_cmd.fin_amp) begin
            n_res.avg_voltage       = r_volt_rd;
            n_res.avg_current       = w_amp_avg;
            n_res.low_voltage_trip  = w_lowv;
            n_res.high_voltage_trip = w_highv;
        end
        if (i_cmd.fin_slow) begin
            n_res.slow_current     = w_slow;
            n_res.ave_current_trip = w_avec;
            n_res.high_temp_trip   = w_hot;
        end
    end

    // item result and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_temp <= w_temp;
        end
        r_res <= n_res;
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    assign o_stat.div_done = w_div_done;
    assign o_cfg_ready     = 1'b1;
    assign o_m_tdata       = r_out;

endmodule

[src/prm_ctrl.sv]
// Controller: sequences item intake, divider runs and result hand-off.
module prm_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [prm_pkg::IN_TUSER_W-1:0] i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    input  prm_pkg::t_stat                 i_stat,
    output prm_pkg::t_cmd                  o_cmd
);
    import prm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_V,
        S_DIV_A,
        S_DIV_S,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_m_valid;
    logic   n_m_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.take = 1'b1;
                    case (t_kind'(i_s_tuser))
                        KIND_FAST: begin
                            o_cmd.div_start = 1'b1;
                            o_cmd.div_sel   = DIV_VOLT;
                            n_state         = S_DIV_V;
                        end
                        KIND_SLOW: begin
                            o_cmd.div_start = 1'b1;
                            o_cmd.div_sel   = DIV_SLOW;
                            n_state         = S_DIV_S;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_DIV_V: begin
                o_cmd.div_sel = DIV_AMP;
                if (i_stat.div_done) begin
                    o_cmd.fin_volt  = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV_A;
                end
            end
            S_DIV_A: begin
                if (i_stat.div_done) begin
                    o_cmd.fin_amp = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_DIV_S: begin
                if (i_stat.div_done) begin
                    o_cmd.fin_slow = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;

endmodule

[src/power_rail_monitor_trip_unit.sv]
// Top level of the power rail monitor trip unit.
//
// Input stream: one item per handshake; tuser carries the kind (sample,
// fast tick, slow tick), tlast marks the last sample of a DMA block.
// Output stream: one result item for every input item, in order, with
// the trip flags, the sample current and the latest averages.
// Config channel: i_cfg_index selects a limit register, i_cfg_data is
// written; always ready, write only while no item is in flight.
// Flow: items are handled one at a time. A sample or unused kind runs
// no division. A fast tick runs two 16-bit divisions on the shared
// radix-4 serial divider; a slow tick runs one 32-bit division.
// The finished result sits in an output register; the next item is
// accepted while it waits, and only the hand-off of the following result
// stalls until the receiver takes it.
// Reset: limits go to their defaults, sums, counters and readings clear.
module power_rail_monitor_trip_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [prm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [prm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // ref_code[9:0], volt_code[19:10], amp_code[29:20], temp_degc[37:30], zero pad
    input  logic [prm_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // kind[1:0]
    input  logic [prm_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // peak_current_trip[0], low_voltage_trip[1], high_voltage_trip[2],
    // ave_current_trip[3], high_temp_trip[4], sample_current[15:5],
    // avg_voltage[31:16], avg_current[47:32], slow_current[63:48]
    output logic [prm_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import prm_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    prm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    prm_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

[src/prm_checker.sv]
// Port-level checks for the power rail monitor trip unit, bound to the top level.
module prm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_tready,
    input logic                            i_s_tvalid,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [prm_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import prm_pkg::*;

    // one item in flight: intake closes right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("intake stayed open after an accepted item");

    // a new result only rises after intake was closed
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result appeared without an item being worked");

    // sample flags never mix with tick flags
    a_flag_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |->
            !(o_m_tdata[1] || o_m_tdata[2] || o_m_tdata[3] || o_m_tdata[4]))
        else $error("peak trip together with a tick trip");

    // sample current and slow average are never both present
    a_field_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[15:5] == 11'd0 || o_m_tdata[63:48] == 16'd0))
        else $error("sample current and slow current in one result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind power_rail_monitor_trip_unit prm_checker u_prm_checker (.*);

[tb/sv/power_rail_monitor_trip_unit_test.sv]
// Self-checking stream testbench for the power rail monitor trip unit.
module power_rail_monitor_trip_unit_test;
    import prm_pkg::*;

    localparam logic [1:0] KIND_UNUSED     = 2'd3;
    localparam int         NUM_PHASES      = 8;
    localparam int         ITEMS_PER_PHASE = 85;
    localparam int         FINAL_ITEMS     = 50;
    localparam int         LONG_HOLD       = 300;
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES    = 60;

    typedef struct packed {
        logic [1:0]        kind;
        logic [9:0]        ref_code;
        logic [9:0]        volt_code;
        logic [9:0]        amp_code;
        logic              block_end;
        logic signed [7:0] temp_degc;
    } rail_item_t;

    typedef struct {
        rail_item_t it;
        bit         has_want;
        t_res       want;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_tuser = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tready = 1'b0;
    logic                   cfg_ready;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // limit copies
    logic [9:0]        lim_peak, lim_lowv, lim_highv, lim_avec;
    logic signed [7:0] lim_temp;
    logic [7:0]        lim_grace;
    // monitor state copies
    logic [15:0] volt_acc, amp_acc, blk_cnt, tick_cnt, volt_avg, amp_avg;
    logic [31:0] long_acc;
    logic [7:0]  grace_cnt;

    t_res pending_results[$];
    int   err_count = 0;
    bit   no_idle = 1'b0;
    bit   long_hold_req = 1'b0;
    int   seq_samples = 0;
    int   seq_blocks = 0;
    int   seq_fasts = 0;

    power_rail_monitor_trip_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic t_res predict_rail(input rail_item_t it);
        t_res   r;
        int     cur, lim, n, v, a, s;
        longint q;
        r = '0;
        case (it.kind)
            KIND_SAMPLE: begin
                cur = it.amp_code;
                cur = cur - int'(it.ref_code);
                lim = lim_peak;
                if (cur > lim || cur < -lim) begin
                    r.peak_current_trip = 1'b1;
                end
                volt_acc = volt_acc + 16'(it.volt_code >> SAMPLE_BITS);
                amp_acc = amp_acc + 16'(cur >>> SAMPLE_BITS);
                if (it.block_end) begin
                    blk_cnt = blk_cnt + 16'd1;
                end
                r.sample_current = 11'(cur);
            end
            KIND_FAST: begin
                n = blk_cnt;
                if (n == 0) begin
                    n = FAST_EMPTY_DIV;
                end
                v = volt_acc;
                volt_avg = 16'(v / n);
                a = $signed(amp_acc);
                a = a / n;
                amp_avg = 16'(a);
                volt_acc = '0;
                amp_acc = '0;
                blk_cnt = '0;
                long_acc = long_acc + 32'(a);
                tick_cnt = tick_cnt + 16'd1;
                if (grace_cnt < lim_grace) begin
                    grace_cnt = grace_cnt + 8'd1;
                end else if (volt_avg < lim_lowv) begin
                    r.low_voltage_trip = 1'b1;
                end
                if (volt_avg > lim_highv) begin
                    r.high_voltage_trip = 1'b1;
                end
            end
            KIND_SLOW: begin
                n = tick_cnt;
                if (n == 0) begin
                    n = SLOW_EMPTY_DIV;
                end
                tick_cnt = '0;
                q = $signed(long_acc);
                q = q / n;
                if (q > 32767) begin
                    q = 32767;
                end
                if (q < -32768) begin
                    q = -32768;
                end
                s = int'(q);
                long_acc = '0;
                lim = lim_avec;
                if (s > lim || s < -lim) begin
                    r.ave_current_trip = 1'b1;
                end
                if (it.temp_degc > lim_temp) begin
                    r.high_temp_trip = 1'b1;
                end
                r.slow_current = 16'(s);
            end
            default: begin
            end
        endcase
        r.avg_voltage = volt_avg;
        r.avg_current = amp_avg;
        return r;
    endfunction

    // mostly block/tick sequences, some noise with any kind
    function automatic rail_item_t next_rail_item();
        rail_item_t it;
        it.kind = KIND_SAMPLE;
        it.ref_code = 10'($urandom);
        it.volt_code = 10'($urandom);
        it.amp_code = 10'($urandom);
        it.block_end = 1'($urandom);
        it.temp_degc = 8'($urandom);
        if ($urandom_range(0, 99) < 10) begin
            it.kind = 2'($urandom);
        end else begin
            if (seq_samples == 0 && seq_blocks > 0) begin
                seq_blocks--;
                seq_samples = $urandom_range(1, 6);
            end
            if (seq_samples > 0) begin
                it.kind = KIND_SAMPLE;
                it.block_end = (seq_samples == 1);
                seq_samples--;
            end else if (seq_fasts > 0) begin
                it.kind = KIND_FAST;
                seq_fasts--;
                seq_blocks = $urandom_range(0, 3);
            end else begin
                it.kind = KIND_SLOW;
                seq_fasts = $urandom_range(1, 5);
                seq_blocks = $urandom_range(0, 3);
            end
        end
        return it;
    endfunction

    function automatic dir_row_t mk_row(input logic [1:0] kind, input logic [9:0] ref_code,
                                        input logic [9:0] volt_code, input logic [9:0] amp_code,
                                        input logic block_end, input logic signed [7:0] temp_degc,
                                        input bit has_want, input t_res want);
        dir_row_t row;
        row.it.kind = kind;
        row.it.ref_code = ref_code;
        row.it.volt_code = volt_code;
        row.it.amp_code = amp_code;
        row.it.block_end = block_end;
        row.it.temp_degc = temp_degc;
        row.has_want = has_want;
        row.want = want;
        return row;
    endfunction

    task automatic send_item(input rail_item_t it, input bit has_want, input t_res want);
        t_res predicted;
        int   gap;
        gap = (no_idle || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 4);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata <= {2'b00, it.temp_degc, it.amp_code, it.volt_code, it.ref_code};
        s_tuser <= it.kind;
        s_tlast <= it.block_end;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        predicted = predict_rail(it);
        pending_results.push_back(has_want ? want : predicted);
    endtask

    task automatic stop_stream();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_PEAK_LIM:  lim_peak = data;
            CFG_LOWV_LIM:  lim_lowv = data;
            CFG_HIGHV_LIM: lim_highv = data;
            CFG_AVEC_LIM:  lim_avec = data;
            CFG_TEMP_LIM:  lim_temp = data[7:0];
            CFG_GRACE:     lim_grace = data[7:0];
            default: begin
            end
        endcase
    endtask

    task automatic apply_limits(input logic [9:0] peak, input logic [9:0] lowv,
                                input logic [9:0] highv, input logic [9:0] avec,
                                input logic signed [7:0] temp, input logic [7:0] grace);
        cfg_write(CFG_PEAK_LIM, peak);
        cfg_write(CFG_LOWV_LIM, lowv);
        cfg_write(CFG_HIGHV_LIM, highv);
        cfg_write(CFG_AVEC_LIM, avec);
        cfg_write(CFG_TEMP_LIM, {2'b00, temp});
        cfg_write(CFG_GRACE, {2'b00, grace});
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic cmp_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    task automatic check_result(input t_res got);
        t_res want;
        if (pending_results.size() == 0) begin
            $display("%0t unexpected result: expected none, got %h", $time, got);
            err_count++;
        end else begin
            want = pending_results.pop_front();
            cmp_field("peak_current_trip", want.peak_current_trip, got.peak_current_trip);
            cmp_field("low_voltage_trip", want.low_voltage_trip, got.low_voltage_trip);
            cmp_field("high_voltage_trip", want.high_voltage_trip, got.high_voltage_trip);
            cmp_field("ave_current_trip", want.ave_current_trip, got.ave_current_trip);
            cmp_field("high_temp_trip", want.high_temp_trip, got.high_temp_trip);
            cmp_field("sample_current", want.sample_current, got.sample_current);
            cmp_field("avg_voltage", want.avg_voltage, got.avg_voltage);
            cmp_field("avg_current", want.avg_current, got.avg_current);
            cmp_field("slow_current", want.slow_current, got.slow_current);
        end
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) begin
                check_result(t_res'(m_tdata));
            end
            @(negedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        dir_row_t   rows[$];
        lim_peak = PEAK_LIM_RST;
        lim_lowv = LOWV_LIM_RST;
        lim_highv = HIGHV_LIM_RST;
        lim_avec = AVEC_LIM_RST;
        lim_temp = TEMP_LIM_RST;
        lim_grace = GRACE_RST;
        volt_acc = '0;
        amp_acc = '0;
        blk_cnt = '0;
        tick_cnt = '0;
        volt_avg = '0;
        amp_avg = '0;
        long_acc = '0;
        grace_cnt = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // current at both edges of the default peak limit
        rows.push_back(mk_row(KIND_SAMPLE, 10'd0, 10'd1023, 10'd1023, 1'b0, 8'sd0, 1'b1,
                              '{sample_current: 11'sd1023, default: '0}));
        rows.push_back(mk_row(KIND_SAMPLE, 10'd1023, 10'd0, 10'd0, 1'b1, -8'sd128, 1'b1,
                              '{sample_current: -11'sd1023, default: '0}));
        // unused kind leaves everything alone
        rows.push_back(mk_row(KIND_UNUSED, 10'd1023, 10'd1023, 10'd1023, 1'b1, 8'sd127, 1'b1,
                              '0));
        // slow tick with no fast ticks yet, temperature at the limit
        rows.push_back(mk_row(KIND_SLOW, 10'd1023, 10'd1023, 10'd1023, 1'b1, 8'sd127, 1'b1,
                              '0));
        // block mark on ticks is ignored
        rows.push_back(mk_row(KIND_FAST, 10'd1023, 10'd1023, 10'd1023, 1'b1, 8'sd0, 1'b0, '0));
        rows.push_back(mk_row(KIND_FAST, 10'd0, 10'd0, 10'd0, 1'b1, 8'sd0, 1'b0, '0));
        rows.push_back(mk_row(KIND_SAMPLE, 10'd512, 10'd512, 10'd512, 1'b0, 8'sd0, 1'b0, '0));
        rows.push_back(mk_row(KIND_SAMPLE, 10'd0, 10'd7, 10'd1, 1'b0, 8'sd0, 1'b0, '0));
        rows.push_back(mk_row(KIND_SAMPLE, 10'd1, 10'd8, 10'd0, 1'b1, 8'sd0, 1'b0, '0));
        rows.push_back(mk_row(KIND_SAMPLE, 10'd0, 10'd1023, 10'd1023, 1'b1, 8'sd0, 1'b0, '0));
        rows.push_back(mk_row(KIND_FAST, 10'd0, 10'd0, 10'd0, 1'b0, 8'sd0, 1'b0, '0));
        rows.push_back(mk_row(KIND_SAMPLE, 10'd1023, 10'd1023, 10'd0, 1'b0, 8'sd0, 1'b0, '0));
        rows.push_back(mk_row(KIND_SAMPLE, 10'd1023, 10'd1023, 10'd0, 1'b0, 8'sd0, 1'b0, '0));
        rows.push_back(mk_row(KIND_SAMPLE, 10'd1023, 10'd1023, 10'd0, 1'b1, 8'sd0, 1'b0, '0));
        rows.push_back(mk_row(KIND_FAST, 10'd0, 10'd0, 10'd0, 1'b0, 8'sd0, 1'b0, '0));
        rows.push_back(mk_row(KIND_SLOW, 10'd0, 10'd0, 10'd0, 1'b0, -8'sd128, 1'b0, '0));
        rows.push_back(mk_row(KIND_SLOW, 10'd0, 10'd0, 10'd0, 1'b1, 8'sd0, 1'b0, '0));
        rows.push_back(mk_row(KIND_UNUSED, 10'd0, 10'd0, 10'd0, 1'b0, 8'sd0, 1'b0, '0));
        rows.push_back(mk_row(KIND_FAST, 10'd0, 10'd0, 10'd0, 1'b0, 8'sd0, 1'b0, '0));
        foreach (rows[k]) begin
            send_item(rows[k].it, rows[k].has_want, rows[k].want);
        end
        stop_stream();

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            case (p)
                0: apply_limits(10'd0, 10'd0, 10'd0, 10'd0, -8'sd128, 8'd0);
                1: apply_limits(10'd1023, 10'd1023, 10'd1023, 10'd1023, 8'sd127, 8'd255);
                2: apply_limits(10'($urandom), 10'($urandom_range(30, 300)),
                                10'($urandom_range(100, 400)), 10'($urandom_range(0, 150)),
                                8'($urandom_range(0, 60) - 20), 8'($urandom_range(0, 8)));
                // grace below the ticks already counted
                3: apply_limits(10'($urandom), 10'd1023, 10'($urandom), 10'($urandom_range(0, 150)),
                                8'($urandom), 8'd3);
                default: apply_limits(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                                      8'($urandom), 8'($urandom));
            endcase
            if (p == 1) begin
                long_hold_req = 1'b1;
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (p == 4 && k == 40) begin
                    stop_stream();
                    drain_results();
                end
                send_item(next_rail_item(), 1'b0, '0);
            end
            stop_stream();
        end

        no_idle = 1'b1;
        drain_results();
        apply_limits(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                     8'($urandom), 8'($urandom));
        repeat (FINAL_ITEMS) begin
            send_item(next_rail_item(), 1'b0, '0);
        end
        stop_stream();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[power_rail_monitor_trip_unit.f]
src/prm_pkg.sv
src/prm_div.sv
src/prm_dpath.sv
src/prm_ctrl.sv
src/power_rail_monitor_trip_unit.sv
src/prm_checker.sv
tb/sv/power_rail_monitor_trip_unit_test.sv
